// ----- hw/rtl/swid_pkg.sv -----
package swid_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DIM_W   = 16;
	localparam int unsigned COUNT_W = 2 * DIM_W;

	// sync word AA 55 AA 55, as its two alternating byte values
	localparam logic [BYTE_W-1:0] SYNC_A = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_B = 8'h55;

	// header byte positions: width lo/hi, height lo/hi
	localparam logic [1:0] HDR_WIDTH_LO  = 2'd0;
	localparam logic [1:0] HDR_WIDTH_HI  = 2'd1;
	localparam logic [1:0] HDR_HEIGHT_LO = 2'd2;
	localparam logic [1:0] HDR_HEIGHT_HI = 2'd3;

	// sync hunt outcome: bytes matched so far, or a full match
	typedef struct packed {
		logic       hit;
		logic [1:0] matched;
	} sync_step_t;

	// overlap-aware partial-match step for the sync word
	function automatic sync_step_t sync_next(input logic [1:0] k, input logic [BYTE_W-1:0] b);
		sync_step_t r;
		r.hit = 1'b0;
		r.matched = (b == SYNC_A) ? 2'd1 : 2'd0;
		case (k)
			2'd1: begin
				if (b == SYNC_B) r.matched = 2'd2;
			end
			2'd2: begin
				r.matched = (b == SYNC_A) ? 2'd3 : 2'd0;
			end
			2'd3: begin
				if (b == SYNC_B) begin
					r.hit = 1'b1;
					r.matched = 2'd0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/sync_word_image_deframer.sv -----
// Sync-word image deframer.
// Input channel (byte_valid / byte_stall / in_byte) takes one stream byte per
// request. The block hunts for the sync word AA 55 AA 55, reads a 4-byte
// little-endian header (width, then height) and forwards width*height payload
// bytes on the result channel (pix_valid / pix_stall), tagging the first and
// last byte of each frame along with the header dimensions. A header that
// announces zero pixels yields a single request with empty_frame set.
// Bytes outside a frame give no result.
// Throughput: one byte per cycle, sustained, as long as results are taken.
// A byte accepted into the input register is processed there by the frame
// state logic, and its result is offered from the output register. The only
// arithmetic is one 16x16 multiply at the last header byte.
// Reset (arst_n low) returns the block to sync hunting and empties both
// registers. While pix_stall is high and a result is offered, it holds, the
// input register keeps its byte and byte_stall rises once it is full.
module sync_word_image_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  logic [swid_pkg::BYTE_W-1:0] in_byte,
	output logic                        pix_valid,
	input  logic                        pix_stall,
	output logic [swid_pkg::BYTE_W-1:0] pixel,
	output logic                        first_pixel,
	output logic                        last_pixel,
	output logic                        empty_frame,
	output logic [swid_pkg::DIM_W-1:0]  frame_width,
	output logic [swid_pkg::DIM_W-1:0]  frame_height
);
	import swid_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [1:0]          sync_q, sync_n;
	logic [1:0]          hdr_idx_q, hdr_idx_n;
	logic [DIM_W-1:0]    width_q, width_n;
	logic [DIM_W-1:0]    height_q, height_n;
	logic [COUNT_W-1:0]  left_q, left_n;
	logic                at_first_q, at_first_n;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;

	logic                res_vld;
	logic [BYTE_W-1:0]   res_pixel;
	logic                res_first, res_last, res_empty;
	logic [COUNT_W-1:0]  size;
	logic [COUNT_W-1:0]  left_dec;
	sync_step_t          hunt;

	logic                adv;
	logic                byte_acc;

	// output register frees up when empty or when its result is taken
	assign adv        = !pix_valid || !pix_stall;
	assign byte_stall = valid_s1 && !adv;
	assign byte_acc   = byte_valid && !byte_stall;

	// frame size as seen at the last header byte (height high byte in flight)
	assign size     = {{DIM_W{1'b0}}, width_q} *
		{{DIM_W{1'b0}}, byte_s1, height_q[BYTE_W-1:0]};
	assign left_dec = (left_q != '0) ? left_q - COUNT_W'(1) : left_q;
	assign hunt     = sync_next(sync_q, byte_s1);

	// frame state update for the byte in the input register
	always_comb begin
		phase_n    = phase_q;
		sync_n     = sync_q;
		hdr_idx_n  = hdr_idx_q;
		width_n    = width_q;
		height_n   = height_q;
		left_n     = left_q;
		at_first_n = at_first_q;
		res_vld    = 1'b0;
		res_pixel  = byte_s1;
		res_first  = at_first_q;
		res_last   = 1'b0;
		res_empty  = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				unique case (hdr_idx_q)
					HDR_WIDTH_LO:  width_n  = {width_q[DIM_W-1:BYTE_W], byte_s1};
					HDR_WIDTH_HI:  width_n  = {byte_s1, width_q[BYTE_W-1:0]};
					HDR_HEIGHT_LO: height_n = {height_q[DIM_W-1:BYTE_W], byte_s1};
					HDR_HEIGHT_HI: height_n = {byte_s1, height_q[BYTE_W-1:0]};
					default: begin
					end
				endcase
				if (hdr_idx_q != HDR_HEIGHT_HI) begin
					hdr_idx_n = hdr_idx_q + 2'd1;
				end else begin
					hdr_idx_n  = '0;
					left_n     = size;
					at_first_n = 1'b1;
					if (size == '0) begin
						// empty frame: one marker result, then back to hunting
						phase_n   = PH_HUNT;
						sync_n    = '0;
						res_vld   = 1'b1;
						res_pixel = '0;
						res_first = 1'b1;
						res_last  = 1'b1;
						res_empty = 1'b1;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res_vld    = 1'b1;
				res_last   = (left_q <= COUNT_W'(1));
				at_first_n = 1'b0;
				left_n     = left_dec;
				if (left_dec == '0) begin
					phase_n    = PH_HUNT;
					sync_n     = '0;
					at_first_n = 1'b1;
				end
			end
			default: begin
				// hunting; the unused code behaves the same
				phase_n = PH_HUNT;
				if (hunt.hit) begin
					sync_n    = '0;
					hdr_idx_n = '0;
					phase_n   = PH_HEADER;
				end else begin
					sync_n = hunt.matched;
				end
			end
		endcase
	end

	// input register, frame state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			byte_s1      <= '0;
			phase_q      <= PH_HUNT;
			sync_q       <= '0;
			hdr_idx_q    <= '0;
			width_q      <= '0;
			height_q     <= '0;
			left_q       <= '0;
			at_first_q   <= 1'b1;
			pix_valid    <= 1'b0;
			pixel        <= '0;
			first_pixel  <= 1'b0;
			last_pixel   <= 1'b0;
			empty_frame  <= 1'b0;
			frame_width  <= '0;
			frame_height <= '0;
		end else begin
			if (adv || !valid_s1) begin
				valid_s1 <= byte_acc;
				if (byte_acc) byte_s1 <= in_byte;
			end
			if (adv) begin
				pix_valid <= valid_s1 && res_vld;
				if (valid_s1) begin
					phase_q      <= phase_n;
					sync_q       <= sync_n;
					hdr_idx_q    <= hdr_idx_n;
					width_q      <= width_n;
					height_q     <= height_n;
					left_q       <= left_n;
					at_first_q   <= at_first_n;
					pixel        <= res_pixel;
					first_pixel  <= res_first;
					last_pixel   <= res_last;
					empty_frame  <= res_empty;
					frame_width  <= width_n;
					frame_height <= height_n;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/swid_checker.sv -----
module swid_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        pix_valid,
	input logic                        pix_stall,
	input logic [swid_pkg::BYTE_W-1:0] pixel,
	input logic                        first_pixel,
	input logic                        last_pixel,
	input logic                        empty_frame,
	input logic [swid_pkg::DIM_W-1:0]  frame_width,
	input logic [swid_pkg::DIM_W-1:0]  frame_height
);
	import swid_pkg::*;

	// a stalled result holds its pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pixel))
		else $error("stalled result changed");

	// empty-frame marker is first and last with a zero pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && empty_frame |-> first_pixel && last_pixel && (pixel == '0))
		else $error("malformed empty-frame marker");

	// a one-pixel frame comes only from a 1x1 header
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !empty_frame && first_pixel && last_pixel
		|-> (frame_width == DIM_W'(1)) && (frame_height == DIM_W'(1)))
		else $error("single pixel frame with wrong size");

	// inside a frame no new frame starts right after a taken byte
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall && !last_pixel
		|=> !(pix_valid && (first_pixel || empty_frame)))
		else $error("frame restarted before its last pixel");

endmodule

bind sync_word_image_deframer swid_checker u_swid_checker (.*);

// ----- dv/sync_word_image_deframer_tb.sv -----
`timescale 1ns / 1ps

module sync_word_image_deframer_tb;

	import swid_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned RANDOM_FRAMED = 950;
	localparam int unsigned HOLD_CYCLES   = 300;

	typedef enum logic [1:0] {
		HUNTING,
		IN_HEADER,
		IN_PAYLOAD
	} frame_phase_t;

	// one expected request on the pixel side
	typedef struct packed {
		logic [BYTE_W-1:0] pixel;
		logic              first;
		logic              last;
		logic              empty;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
	} pixel_out_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              byte_valid = 1'b0;
	logic              byte_stall;
	logic [BYTE_W-1:0] in_byte = '0;
	logic              pix_valid;
	logic              pix_stall = 1'b0;
	logic [BYTE_W-1:0] pixel;
	logic              first_pixel;
	logic              last_pixel;
	logic              empty_frame;
	logic [DIM_W-1:0]  frame_width;
	logic [DIM_W-1:0]  frame_height;

	// deframer prediction state
	frame_phase_t       frm_phase = HUNTING;
	logic [1:0]         sync_cnt = '0;
	logic [1:0]         hdr_pos = '0;
	logic [DIM_W-1:0]   hdr_width = '0;
	logic [DIM_W-1:0]   hdr_height = '0;
	logic [COUNT_W-1:0] pixels_left = '0;
	logic               first_next = 1'b1;

	pixel_out_t pending_pixels[$];

	// stimulus control; gaps_on and hold_req are shared with the pixel sink
	bit          gaps_on = 1'b1;
	bit          bus_busy = 1'b0;
	int unsigned hold_req = 0;

	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned frames_seen = 0;
	int unsigned empties_seen = 0;
	int unsigned bytes_sent = 0;
	int unsigned framed_bytes = 0;
	int unsigned stall_cycles = 0;
	int unsigned cycle_count = 0;

	sync_word_image_deframer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.in_byte      (in_byte),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.pixel        (pixel),
		.first_pixel  (first_pixel),
		.last_pixel   (last_pixel),
		.empty_frame  (empty_frame),
		.frame_width  (frame_width),
		.frame_height (frame_height)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("sync_word_image_deframer test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (byte_valid && byte_stall)
			stall_cycles++;
	end

	// advance the deframer by one accepted byte; queue the pixel it yields
	task automatic deframe_byte(input logic [BYTE_W-1:0] b);
		logic [COUNT_W-1:0] w32;
		logic [COUNT_W-1:0] h32;
		logic [BYTE_W-1:0]  want;
		pixel_out_t         px;
		if (frm_phase != HUNTING)
			framed_bytes++;
		case (frm_phase)
			IN_HEADER: begin
				case (hdr_pos)
					HDR_WIDTH_LO:  hdr_width[7:0]   = b;
					HDR_WIDTH_HI:  hdr_width[15:8]  = b;
					HDR_HEIGHT_LO: hdr_height[7:0]  = b;
					default:       hdr_height[15:8] = b;
				endcase
				if (hdr_pos != HDR_HEIGHT_HI) begin
					hdr_pos = hdr_pos + 2'd1;
				end else begin
					hdr_pos = HDR_WIDTH_LO;
					w32 = COUNT_W'(hdr_width);
					h32 = COUNT_W'(hdr_height);
					pixels_left = w32 * h32;
					first_next = 1'b1;
					if (pixels_left == 0) begin
						// zero-size frame: one marker, straight back to hunting
						frm_phase = HUNTING;
						sync_cnt = '0;
						px = '{pixel: '0, first: 1'b1, last: 1'b1, empty: 1'b1,
							width: hdr_width, height: hdr_height};
						pending_pixels.push_back(px);
					end else begin
						frm_phase = IN_PAYLOAD;
					end
				end
			end
			IN_PAYLOAD: begin
				px = '{pixel: b, first: first_next, last: (pixels_left <= 1), empty: 1'b0,
					width: hdr_width, height: hdr_height};
				pending_pixels.push_back(px);
				first_next = 1'b0;
				if (pixels_left != 0)
					pixels_left = pixels_left - 1;
				if (pixels_left == 0) begin
					frm_phase = HUNTING;
					sync_cnt = '0;
					first_next = 1'b1;
				end
			end
			default: begin
				// pattern alternates A,B; on a miss only a fresh A restarts the match
				frm_phase = HUNTING;
				want = sync_cnt[0] ? SYNC_B : SYNC_A;
				if (b == want && sync_cnt == 2'd3) begin
					sync_cnt = '0;
					hdr_pos = HDR_WIDTH_LO;
					frm_phase = IN_HEADER;
				end else if (b == want) begin
					sync_cnt = sync_cnt + 2'd1;
				end else begin
					sync_cnt = (b == SYNC_A) ? 2'd1 : 2'd0;
				end
			end
		endcase
	endtask

	// offer one byte, wait for its request to be taken, then predict
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			if (bus_busy)
				byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		in_byte <= b;
		bus_busy = 1'b1;
		do @(posedge clk); while (byte_stall);
		bytes_sent++;
		deframe_byte(b);
	endtask

	task automatic stop_bytes();
		if (bus_busy) begin
			byte_valid <= 1'b0;
			bus_busy = 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drain();
		stop_bytes();
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_sync();
		send_byte(SYNC_A);
		send_byte(SYNC_B);
		send_byte(SYNC_A);
		send_byte(SYNC_B);
	endtask

	task automatic send_header(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		send_byte(w[7:0]);
		send_byte(w[15:8]);
		send_byte(h[7:0]);
		send_byte(h[15:8]);
	endtask

	// full frame with random payload; breaks a partial match that would lock early
	task automatic send_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		logic [COUNT_W-1:0] total;
		logic [COUNT_W-1:0] w32;
		logic [COUNT_W-1:0] h32;
		if (sync_cnt == 2'd2)
			send_byte(8'h00);
		send_sync();
		send_header(w, h);
		w32 = COUNT_W'(w);
		h32 = COUNT_W'(h);
		total = w32 * h32;
		for (logic [COUNT_W-1:0] i = 0; i < total; i++)
			send_byte(BYTE_W'($urandom_range(0, 255)));
	endtask

	// out-of-frame byte that never completes a sync word
	task automatic send_noise(input logic [BYTE_W-1:0] b);
		if (frm_phase == HUNTING && sync_cnt == 2'd3 && b == SYNC_B)
			b = 8'h00;
		send_byte(b);
	endtask

	function automatic logic [BYTE_W-1:0] pick_noise();
		case ($urandom_range(0, 3))
			0: return SYNC_A;
			1: return SYNC_B;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// pixel sink: random hold-off per request, plus long holds on demand
	initial begin : pixel_sink
		int unsigned wait_cycles;
		forever begin
			if (hold_req != 0) begin
				wait_cycles = hold_req;
				hold_req = 0;
			end else begin
				wait_cycles = gaps_on ? $urandom_range(0, 7) : 0;
			end
			if (wait_cycles != 0) begin
				pix_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			pix_stall <= 1'b0;
			do @(posedge clk); while (!pix_valid);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	// compare every taken pixel request with the oldest prediction
	always @(posedge clk) begin : pixel_check
		pixel_out_t px;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel request, expected none, got pixel %0h",
					$time, pixel);
				mismatches++;
			end else begin
				px = pending_pixels.pop_front();
				check_field("pixel", 32'(px.pixel), 32'(pixel));
				check_field("first_pixel", 32'(px.first), 32'(first_pixel));
				check_field("last_pixel", 32'(px.last), 32'(last_pixel));
				check_field("empty_frame", 32'(px.empty), 32'(empty_frame));
				check_field("frame_width", 32'(px.width), 32'(frame_width));
				check_field("frame_height", 32'(px.height), 32'(frame_height));
				results_checked++;
				if (px.first)
					frames_seen++;
				if (px.empty)
					empties_seen++;
			end
		end
	end

	// partial matches, a broken sync, then an overlapping lock
	task automatic test_sync_hunt();
		send_byte(SYNC_B);
		send_byte(SYNC_A);
		send_byte(SYNC_B);
		send_byte(SYNC_A);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYNC_A);
		send_byte(SYNC_B);
		send_byte(SYNC_A);
		send_sync();
		send_header(16'd1, 16'd1);
		send_byte(8'hFF);
		wait_drain();
	endtask

	// zero-size headers, each dimension at its maximum once
	task automatic test_empty_frames();
		send_frame(16'd0, 16'd0);
		send_frame(16'hFFFF, 16'd0);
		send_frame(16'd0, 16'hFFFF);
		wait_drain();
	endtask

	// sync word inside a payload is plain data; trailing bytes are dropped
	task automatic test_sync_inside_frame();
		send_sync();
		send_header(16'd6, 16'd1);
		send_sync();
		send_byte(8'h01);
		send_byte(8'h00);
		send_header(16'd1, 16'd1);
		send_frame(16'd1, 16'd1);
		wait_drain();
	endtask

	// frames that use the high header byte of each dimension, no idling
	task automatic test_max_frames();
		gaps_on = 1'b0;
		send_frame(16'h0101, 16'd1);
		send_frame(16'd1, 16'h0102);
		wait_drain();
		gaps_on = 1'b1;
	endtask

	// sink holds off while the stream keeps coming, so the input backs up
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_req = HOLD_CYCLES;
		send_frame(16'd8, 16'd8);
		wait_drain();
		gaps_on = 1'b1;
		send_frame(16'd3, 16'd2);
		wait_drain();
	endtask

	// mostly well-formed frames with random content, some noise and broken syncs
	task automatic test_random_stream();
		int unsigned start;
		int unsigned n;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		start = framed_bytes;
		while (framed_bytes - start < RANDOM_FRAMED) begin
			if ($urandom_range(0, 39) == 0)
				gaps_on = !gaps_on;
			n = $urandom_range(0, 3);
			repeat (n) send_noise(pick_noise());
			case ($urandom_range(0, 19))
				0, 1: begin
					// broken sync: a prefix, then a random byte
					n = $urandom_range(1, 3);
					if (sync_cnt != 0)
						send_byte(8'h00);
					for (int i = 0; i < n; i++)
						send_noise((i % 2 == 0) ? SYNC_A : SYNC_B);
					send_noise(BYTE_W'($urandom_range(0, 255)));
				end
				2: begin
					w = DIM_W'($urandom_range(0, 65535));
					if ($urandom_range(0, 1) == 0)
						send_frame(w, 16'd0);
					else
						send_frame(16'd0, w);
				end
				3: begin
					// leading partial match that overlaps the real sync
					if (sync_cnt != 0)
						send_byte(8'h00);
					send_byte(SYNC_A);
					send_byte(SYNC_B);
					send_byte(SYNC_A);
					send_frame(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)));
				end
				4: begin
					send_frame(DIM_W'($urandom_range(1, 64)), 16'd1);
				end
				5: begin
					send_frame(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)));
					wait_drain();
				end
				default: begin
					send_frame(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)));
				end
			endcase
		end
		wait_drain();
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sync_hunt();
		test_empty_frames();
		test_sync_inside_frame();
		test_max_frames();
		test_backpressure();
		test_random_stream();
		wait_drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes (%0d inside frames); checked %0d pixel requests",
			bytes_sent, framed_bytes, results_checked);
		$display("Frames: %0d, empty: %0d; input held off %0d cycles by back-pressure",
			frames_seen, empties_seen, stall_cycles);
		if (mismatches == 0 && pending_pixels.size() == 0) begin
			$display("sync_word_image_deframer test passed");
		end else begin
			$display("sync_word_image_deframer test failed");
		end
		$finish;
	end

endmodule

// ----- sync_word_image_deframer.f -----
hw/rtl/swid_pkg.sv
hw/rtl/sync_word_image_deframer.sv
hw/rtl/swid_checker.sv
dv/sync_word_image_deframer_tb.sv
